// ----- src/framed_packet_receiver_macros.svh -----
// Assertion macros shared by the framed packet receiver RTL.
`ifndef FRAMED_PACKET_RECEIVER_MACROS_SVH
`define FRAMED_PACKET_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FPR_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("framed_packet_receiver: assertion failed");

// Next-cycle implication, disabled during reset.
`define FPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("framed_packet_receiver: assertion failed");

`endif

// ----- src/fpr_pkg.sv -----
// Shared constants and types of the framed packet receiver.
package fpr_pkg;

   localparam int FRAME_BYTES = 32;
   localparam int MAX_RESULTS = 24;
   localparam int MIN_LENGTH  = 6;
   localparam int LEN_CAP     = ((FRAME_BYTES - 2) < (MAX_RESULTS + MIN_LENGTH)) ?
                                (FRAME_BYTES - 2) : (MAX_RESULTS + MIN_LENGTH);
   localparam int DATA_BASE   = 5;
   localparam int CNT_W       = $clog2(FRAME_BYTES);
   localparam int BYTE_W      = 8;
   localparam int PIDX_W      = 5;
   localparam int SUM_W       = 16;
   localparam int CSR_IDX_W   = 4;

   localparam logic [CSR_IDX_W-1:0] REG_START_CODE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_END_CODE   = CSR_IDX_W'(1);

   localparam logic [BYTE_W-1:0] START_CODE_RESET = 8'hAA;
   localparam logic [BYTE_W-1:0] END_CODE_RESET   = 8'h55;

   typedef struct packed {
      logic req_ready;
      logic clear;
      logic store;
      logic emit_err;
      logic emit_nodata;
      logic rd_clear;
      logic rd_issue;
      logic emit_data;
   } cmd_type;

   typedef struct packed {
      logic is_start;
      logic is_end;
      logic count_zero;
      logic count_eq_len;
      logic len_bad;
      logic sum_ok;
      logic nd_zero;
      logic k_last;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic              status;
      logic [BYTE_W-1:0] frame_type;
      logic [BYTE_W-1:0] frame_addr;
      logic [BYTE_W-1:0] function_code;
      logic              has_data;
      logic [BYTE_W-1:0] payload_byte;
      logic [PIDX_W-1:0] payload_index;
      logic              last;
   } rsp_item_type;

endpackage

// ----- src/fpr_req_if.sv -----
// Input byte channel of the framed packet receiver.
interface fpr_req_if import fpr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- src/fpr_rsp_if.sv -----
// Result channel of the framed packet receiver.
interface fpr_rsp_if import fpr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              status;
   logic [BYTE_W-1:0] frame_type;
   logic [BYTE_W-1:0] frame_addr;
   logic [BYTE_W-1:0] function_code;
   logic              has_data;
   logic [BYTE_W-1:0] payload_byte;
   logic [PIDX_W-1:0] payload_index;
   logic              last;

   modport source (output valid, output status, output frame_type, output frame_addr,
                   output function_code, output has_data, output payload_byte,
                   output payload_index, output last, input ready);
   modport sink (input valid, input status, input frame_type, input frame_addr,
                 input function_code, input has_data, input payload_byte,
                 input payload_index, input last, output ready);
endinterface

// ----- src/fpr_csr_if.sv -----
// Configuration write channel of the framed packet receiver.
interface fpr_csr_if import fpr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [BYTE_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/framed_packet_receiver.sv -----
// Framed packet receiver top level: controller, datapath and channel hookup.
// Results: a single result is registered in the cycle after the frame's end byte;
// data results are registered after the READ and LOAD states that read the frame store.
// Throughput: one byte a cycle in receive, but an end byte waits for a free output;
// data results wait on the registered frame store read; no bytes are taken meanwhile.
// Reset: synchronous, active high; the block hunts and the codes return to 0xAA / 0x55.
module framed_packet_receiver import fpr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   fpr_req_if.sink   req_bus,
   fpr_rsp_if.source rsp_bus,
   fpr_csr_if.sink   csr_bus
);

`include "framed_packet_receiver_macros.svh"

   cmd_type      cmd;
   status_type   stat;
   rsp_item_type rsp_item;

   fpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   fpr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .rx_byte   (req_bus.rx_byte),
      .csr_write (csr_bus.valid),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.data),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_item  (rsp_item)
   );

   assign req_bus.ready         = cmd.req_ready;
   assign csr_bus.ready         = 1'b1;
   assign rsp_bus.status        = rsp_item.status;
   assign rsp_bus.frame_type    = rsp_item.frame_type;
   assign rsp_bus.frame_addr    = rsp_item.frame_addr;
   assign rsp_bus.function_code = rsp_item.function_code;
   assign rsp_bus.has_data      = rsp_item.has_data;
   assign rsp_bus.payload_byte  = rsp_item.payload_byte;
   assign rsp_bus.payload_index = rsp_item.payload_index;
   assign rsp_bus.last          = rsp_item.last;

   `FPR_ASSERT_IMPLIES(a_no_accept_while_reading, clock, reset, cmd.rd_issue, !req_bus.ready)
   `FPR_ASSERT_IMPLIES(a_error_is_single, clock, reset, rsp_bus.valid && rsp_bus.status, rsp_bus.last && !rsp_bus.has_data)
   `FPR_ASSERT_IMPLIES(a_nodata_is_last, clock, reset, rsp_bus.valid && !rsp_bus.has_data, rsp_bus.last)
   `FPR_ASSERT_NEXT(a_read_then_load, clock, reset, cmd.rd_issue, !cmd.rd_issue && !req_bus.ready)

endmodule

// ----- src/fpr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/fpr_ctrl.sv -----
// Frame controller state machine of the framed packet receiver.
module fpr_ctrl import fpr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type stat,
   output cmd_type    cmd
);

   localparam logic [1:0] S_HUNT = 2'd0;
   localparam logic [1:0] S_RECV = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_LOAD = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       close_pending;
   logic       accept;

   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      close_pending = !stat.count_zero && stat.count_eq_len;
      accept        = 1'b0;
      case (state_ff)
         S_HUNT: begin
            cmd.req_ready = 1'b1;
            if (req_valid && stat.is_start) begin
               cmd.clear = 1'b1;
               state_in  = S_RECV;
            end
         end
         S_RECV: begin
            cmd.req_ready = !close_pending || stat.out_free;
            accept        = req_valid && cmd.req_ready;
            if (accept) begin
               if (close_pending && stat.is_end) begin
                  cmd.clear = 1'b1;
                  if (!stat.sum_ok) begin
                     cmd.emit_err = 1'b1;
                     state_in     = S_HUNT;
                  end else if (stat.nd_zero) begin
                     cmd.emit_nodata = 1'b1;
                     state_in        = S_HUNT;
                  end else begin
                     cmd.rd_clear = 1'b1;
                     state_in     = S_READ;
                  end
               end else if (close_pending) begin
                  cmd.clear = 1'b1;
                  state_in  = S_HUNT;
               end else if (stat.count_zero && stat.len_bad) begin
                  cmd.clear = 1'b1;
                  state_in  = S_HUNT;
               end else begin
                  cmd.store = 1'b1;
               end
            end
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_LOAD;
         end
         S_LOAD: begin
            if (stat.out_free) begin
               cmd.emit_data = 1'b1;
               state_in      = stat.k_last ? S_HUNT : S_READ;
            end
         end
         default: begin
            state_in = S_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/fpr_datapath.sv -----
// Frame datapath: counters, checksum, header capture, frame store and result register.
module fpr_datapath import fpr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           stat,
   input  logic [BYTE_W-1:0]    rx_byte,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output rsp_item_type         rsp_item
);

   logic [BYTE_W-1:0] start_ff, start_in;
   logic [BYTE_W-1:0] end_ff, end_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [BYTE_W-1:0] type_ff, type_in;
   logic [BYTE_W-1:0] addr_ff, addr_in;
   logic [BYTE_W-1:0] func_ff, func_in;
   logic [BYTE_W-1:0] ck_hi_ff, ck_hi_in;
   logic [BYTE_W-1:0] ck_lo_ff, ck_lo_in;
   logic [PIDX_W-1:0] k_ff, k_in;
   logic              out_valid_ff, out_valid_in;
   rsp_item_type      out_ff, out_in;

   logic [CNT_W:0]    new_count;
   logic [CNT_W-1:0]  len_eff;
   logic              sum_add;
   logic [CNT_W-1:0]  raddr;
   logic [BYTE_W-1:0] rdata;

   assign new_count = {1'b0, count_ff} + (CNT_W+1)'(1);
   assign len_eff   = (count_ff == '0) ? rx_byte[CNT_W-1:0] : len_ff;
   assign sum_add   = ((CNT_W+2)'(new_count) + (CNT_W+2)'(2)) <= (CNT_W+2)'(len_eff);
   assign raddr     = CNT_W'(DATA_BASE) + CNT_W'(k_ff);

   always_comb begin
      stat.is_start     = rx_byte == start_ff;
      stat.is_end       = rx_byte == end_ff;
      stat.count_zero   = count_ff == '0;
      stat.count_eq_len = count_ff == len_ff;
      stat.len_bad      = (rx_byte < BYTE_W'(MIN_LENGTH)) || (rx_byte > BYTE_W'(LEN_CAP));
      stat.sum_ok       = sum_ff == {ck_hi_ff, ck_lo_ff};
      stat.nd_zero      = len_ff == CNT_W'(MIN_LENGTH);
      stat.k_last       = ((CNT_W+1)'(k_ff) + (CNT_W+1)'(MIN_LENGTH + 1)) ==
                          (CNT_W+1)'(len_ff);
      stat.out_free     = !out_valid_ff || rsp_ready;
   end

   always_comb begin
      start_in     = start_ff;
      end_in       = end_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      sum_in       = sum_ff;
      type_in      = type_ff;
      addr_in      = addr_ff;
      func_in      = func_ff;
      ck_hi_in     = ck_hi_ff;
      ck_lo_in     = ck_lo_ff;
      k_in         = k_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;

      if (csr_write) begin
         case (csr_index)
            REG_START_CODE: start_in = csr_data;
            REG_END_CODE:   end_in   = csr_data;
            default: begin
            end
         endcase
      end

      if (cmd.clear) begin
         count_in = '0;
         sum_in   = '0;
      end else if (cmd.store) begin
         count_in = new_count[CNT_W-1:0];
         ck_hi_in = ck_lo_ff;
         ck_lo_in = rx_byte;
         if (count_ff == '0) begin
            len_in = rx_byte[CNT_W-1:0];
         end
         if (sum_add) begin
            sum_in = sum_ff + SUM_W'(rx_byte);
         end
         if (new_count == (CNT_W+1)'(2)) begin
            type_in = rx_byte;
         end
         if (new_count == (CNT_W+1)'(3)) begin
            addr_in = rx_byte;
         end
         if (new_count == (CNT_W+1)'(4)) begin
            func_in = rx_byte;
         end
      end

      if (cmd.rd_clear) begin
         k_in = '0;
      end else if (cmd.emit_data) begin
         k_in = k_ff + PIDX_W'(1);
      end

      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.emit_err) begin
         out_valid_in = 1'b1;
         out_in       = '0;
         out_in.status = 1'b1;
         out_in.last   = 1'b1;
      end else if (cmd.emit_nodata) begin
         out_valid_in         = 1'b1;
         out_in               = '0;
         out_in.frame_type    = type_ff;
         out_in.frame_addr    = addr_ff;
         out_in.function_code = func_ff;
         out_in.last          = 1'b1;
      end else if (cmd.emit_data) begin
         out_valid_in         = 1'b1;
         out_in.status        = 1'b0;
         out_in.frame_type    = type_ff;
         out_in.frame_addr    = addr_ff;
         out_in.function_code = func_ff;
         out_in.has_data      = 1'b1;
         out_in.payload_byte  = rdata;
         out_in.payload_index = k_ff;
         out_in.last          = stat.k_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= START_CODE_RESET;
         end_ff       <= END_CODE_RESET;
         count_ff     <= '0;
         len_ff       <= '0;
         sum_ff       <= '0;
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         end_ff       <= end_in;
         count_ff     <= count_in;
         len_ff       <= len_in;
         sum_ff       <= sum_in;
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff  <= type_in;
      addr_ff  <= addr_in;
      func_ff  <= func_in;
      ck_hi_ff <= ck_hi_in;
      ck_lo_ff <= ck_lo_in;
      out_ff   <= out_in;
   end

   fpr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FRAME_BYTES)
   ) u_store (
      .clock (clock),
      .we    (cmd.store),
      .waddr (new_count[CNT_W-1:0]),
      .wdata (rx_byte),
      .re    (cmd.rd_issue),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the framed packet receiver: stimulus, predictor, checks.
module tb import fpr_pkg::*; ();

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = '1;

   logic clock;
   logic reset;

   fpr_req_if req_bus ();
   fpr_rsp_if rsp_bus ();
   fpr_csr_if csr_bus ();

   framed_packet_receiver u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   logic [BYTE_W-1:0] rx_pending[$];
   rsp_item_type      frame_results_due[$];
   int                rx_count;
   int                mismatches;
   bit                idle_off;
   int                req_gap;
   int                rsp_stall;

   logic [BYTE_W-1:0] start_code_q;
   logic [BYTE_W-1:0] end_code_q;
   bit                in_frame;
   int                frame_len;
   int                frame_cnt;
   logic [BYTE_W-1:0] frame_mem [0:FRAME_BYTES-1];
   logic [SUM_W-1:0]  running_csum;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (idle_off || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic void return_to_hunt();
      in_frame = 1'b0;
      frame_len = 0;
      frame_cnt = 0;
      running_csum = '0;
   endfunction

   function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
      logic [SUM_W-1:0] got_sum;
      int               n_data;
      rsp_item_type     res;
      if (!in_frame) begin
         if (b == start_code_q) begin
            return_to_hunt();
            in_frame = 1'b1;
         end
         return;
      end
      if (frame_cnt != 0 && b == end_code_q && frame_cnt == frame_len) begin
         got_sum = {frame_mem[frame_len-1], frame_mem[frame_len]};
         n_data = frame_len - MIN_LENGTH;
         res = '0;
         res.last = 1'b1;
         if (running_csum != got_sum) begin
            res.status = 1'b1;
            frame_results_due.push_back(res);
         end else begin
            res.frame_type = frame_mem[2];
            res.frame_addr = frame_mem[3];
            res.function_code = frame_mem[4];
            if (n_data == 0) begin
               frame_results_due.push_back(res);
            end else begin
               for (int k = 0; k < n_data && k < MAX_RESULTS; k++) begin
                  res.has_data = 1'b1;
                  res.payload_byte = frame_mem[DATA_BASE+k];
                  res.payload_index = PIDX_W'(k);
                  res.last = (k == n_data - 1);
                  frame_results_due.push_back(res);
               end
            end
         end
         return_to_hunt();
         return;
      end
      if (frame_cnt != 0 && frame_cnt >= frame_len) begin
         return_to_hunt();
         return;
      end
      frame_cnt++;
      if (frame_cnt < FRAME_BYTES) frame_mem[frame_cnt] = b;
      if (frame_cnt == 1) begin
         if (b < BYTE_W'(MIN_LENGTH) || b > BYTE_W'(LEN_CAP)) begin
            return_to_hunt();
            return;
         end
         frame_len = int'(b);
      end
      if (frame_cnt + 2 <= frame_len) running_csum = running_csum + SUM_W'(b);
   endfunction

   task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                              input logic [BYTE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_result();
      rsp_item_type want;
      if (frame_results_due.size() == 0) begin
         $error("unexpected result item");
         mismatches++;
         return;
      end
      want = frame_results_due.pop_front();
      check_field("status", BYTE_W'(want.status), BYTE_W'(rsp_bus.status));
      check_field("frame_type", want.frame_type, rsp_bus.frame_type);
      check_field("frame_addr", want.frame_addr, rsp_bus.frame_addr);
      check_field("function_code", want.function_code, rsp_bus.function_code);
      check_field("has_data", BYTE_W'(want.has_data), BYTE_W'(rsp_bus.has_data));
      check_field("payload_byte", want.payload_byte, rsp_bus.payload_byte);
      check_field("payload_index", BYTE_W'(want.payload_index),
                  BYTE_W'(rsp_bus.payload_index));
      check_field("last", BYTE_W'(want.last), BYTE_W'(rsp_bus.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid) deframe_byte(req_bus.rx_byte);
         if (req_gap > 0) begin
            req_bus.valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (rx_pending.size() > 0) begin
            req_bus.valid <= 1'b1;
            req_bus.rx_byte <= rx_pending.pop_front();
            req_gap <= pick_gap();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) check_result();
         if (rsp_stall > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall <= rsp_stall - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_stall <= pick_gap();
         end
      end
   end

   function automatic void push_rx(input logic [BYTE_W-1:0] b);
      rx_pending.push_back(b);
      rx_count++;
   endfunction

   function automatic logic [BYTE_W-1:0] field_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 8'h00;
      if (r < 30) return 8'hFF;
      return BYTE_W'($urandom);
   endfunction

   function automatic void queue_flush();
      logic [BYTE_W-1:0] v;
      v = 8'hFF;
      while (v == start_code_q || v == end_code_q) v = v - 8'd1;
      repeat (LEN_CAP + 1) push_rx(v);
   endfunction

   function automatic void queue_frame(input logic [BYTE_W-1:0] ftype, faddr, fcode,
                                       input int nd, input bit bad_sum, input bit overrun,
                                       input int fill);
      logic [BYTE_W-1:0] body[$];
      logic [SUM_W-1:0]  csum;
      logic [BYTE_W-1:0] tail;
      csum = '0;
      body.push_back(BYTE_W'(nd + MIN_LENGTH));
      body.push_back(ftype);
      body.push_back(faddr);
      body.push_back(fcode);
      for (int k = 0; k < nd; k++)
         body.push_back(fill < 0 ? BYTE_W'($urandom) : BYTE_W'(fill));
      foreach (body[i]) csum = csum + SUM_W'(body[i]);
      if (bad_sum) csum = csum ^ SUM_W'($urandom_range(1, 65535));
      push_rx(start_code_q);
      foreach (body[i]) push_rx(body[i]);
      push_rx(csum[15:8]);
      push_rx(csum[7:0]);
      tail = end_code_q;
      if (overrun) while (tail == end_code_q) tail = BYTE_W'($urandom);
      push_rx(tail);
   endfunction

   function automatic int data_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return $urandom_range(0, 4);
      if (r < 88) return $urandom_range(5, 12);
      if (r < 95) return $urandom_range(13, MAX_RESULTS - 1);
      return MAX_RESULTS;
   endfunction

   function automatic void queue_random_item();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 65) begin
         queue_frame(field_byte(), field_byte(), field_byte(), data_count(), 1'b0, 1'b0, -1);
      end else if (r < 75) begin
         queue_frame(field_byte(), field_byte(), field_byte(), data_count(), 1'b1, 1'b0, -1);
      end else if (r < 82) begin
         push_rx(start_code_q);
         push_rx($urandom_range(0, 1) ? BYTE_W'($urandom_range(0, MIN_LENGTH - 1))
                                      : BYTE_W'($urandom_range(LEN_CAP + 1, 255)));
      end else if (r < 89) begin
         queue_frame(field_byte(), field_byte(), field_byte(), data_count(), 1'b0, 1'b1, -1);
      end else if (r < 95) begin
         n = $urandom_range(1, 12);
         repeat (n) push_rx($urandom_range(0, 3) == 0 ? start_code_q : BYTE_W'($urandom));
         queue_flush();
      end else begin
         n = $urandom_range(MIN_LENGTH, LEN_CAP);
         push_rx(start_code_q);
         push_rx(BYTE_W'(n));
         repeat ($urandom_range(0, n - 2)) push_rx(BYTE_W'($urandom));
         queue_flush();
      end
   endfunction

   task automatic settle();
      while (rx_pending.size() != 0 || req_bus.valid || frame_results_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (idx == REG_START_CODE) start_code_q = val;
      else if (idx == REG_END_CODE) end_code_q = val;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic run_random(input int count);
      int mark;
      mark = rx_count;
      while (rx_count - mark < count) queue_random_item();
      settle();
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.rx_byte = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      rx_count = 0;
      mismatches = 0;
      idle_off = 1'b0;
      start_code_q = START_CODE_RESET;
      end_code_q = END_CODE_RESET;
      return_to_hunt();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      queue_frame(8'hFF, 8'h00, 8'hFF, 0, 1'b0, 1'b0, -1);
      push_rx(start_code_q);
      push_rx(BYTE_W'(MIN_LENGTH - 1));
      push_rx(start_code_q);
      push_rx(end_code_q);
      queue_frame(8'h00, 8'hFF, 8'h00, 2, 1'b1, 1'b0, start_code_q);
      queue_frame(8'h5A, 8'hA5, 8'h3C, 0, 1'b0, 1'b1, -1);
      settle();
      run_random(100);

      write_reg(REG_START_CODE, 8'h00);
      write_reg(REG_END_CODE, 8'hFF);
      write_reg(REG_UNUSED, BYTE_W'($urandom));
      idle_off = 1'b1;
      run_random(100);
      idle_off = 1'b0;

      write_reg(REG_START_CODE, 8'hFF);
      write_reg(REG_END_CODE, 8'h00);
      run_random(100);

      write_reg(REG_START_CODE, BYTE_W'($urandom));
      write_reg(REG_END_CODE, BYTE_W'($urandom));
      run_random(100);

      repeat (20) @(posedge clock);
      if (mismatches == 0 && frame_results_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+src
src/fpr_pkg.sv
src/fpr_req_if.sv
src/fpr_rsp_if.sv
src/fpr_csr_if.sv
src/fpr_ram.sv
src/fpr_ctrl.sv
src/fpr_datapath.sv
src/framed_packet_receiver.sv
verif/tb.sv
